// ----- sv/mrp_pkg.sv -----
// Package with the shared types and constants of the MRP to quaternion pipeline.
`timescale 1ns / 1ps
`default_nettype none
package mrp_pkg;

  localparam int FRAC_BITS = 30;
  localparam int VEC_SHIFT = 25;
  localparam logic [63:0] ONE_Q48 = 64'd1 << 48;
  localparam logic [30:0] ONE_Q30 = 31'd1 << FRAC_BITS;

  typedef struct packed {
    logic signed [31:0] sigma_x;
    logic signed [31:0] sigma_y;
    logic signed [31:0] sigma_z;
    logic               shadow;
  } mrp_in_t;

  typedef struct packed {
    logic signed [31:0] quat_scalar;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
  } quat_t;

  // Component magnitudes, their signs and squares, and the shadow flag.
  typedef struct packed {
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic [2:0][63:0] sq;
    logic             shadow;
  } sq_t;

  // Denominator and numerators; lane 0 is the scalar part.
  typedef struct packed {
    logic [63:0]      den;
    logic [3:0][63:0] num;
    logic [3:0]       neg;
  } sum_t;

  // Partial remainders and quotients of the four divisions.
  typedef struct packed {
    logic [63:0]      den;
    logic [3:0][63:0] rem;
    logic [3:0][30:0] quo;
    logic [3:0]       neg;
  } div_t;

endpackage
`default_nettype wire

// ----- sv/mrp_stream_if.sv -----
// Valid/ready stream interface that carries one payload per beat.
`timescale 1ns / 1ps
`default_nettype none
interface mrp_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/mrp_square.sv -----
// First stage: component magnitudes and their squares.
`timescale 1ns / 1ps
`default_nettype none
module mrp_square
  import mrp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    up_valid,
  output logic    up_ready,
  input  mrp_in_t up_data,
  output logic    dn_valid,
  input  logic    dn_ready,
  output sq_t     dn_data
);
  logic [2:0][31:0] comp;
  sq_t              sq_next;

  assign comp = {up_data.sigma_z, up_data.sigma_y, up_data.sigma_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_next.neg[i] = comp[i][31];
      sq_next.mag[i] = comp[i][31] ? 32'd0 - comp[i] : comp[i];
      sq_next.sq[i]  = 64'(sq_next.mag[i]) * 64'(sq_next.mag[i]);
    end
    sq_next.shadow = up_data.shadow;
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      dn_data <= sq_next;
    end
  end
endmodule
`default_nettype wire

// ----- sv/mrp_prep.sv -----
// Two stages: sum of squares with numerators, then the leading quotient bit.
`timescale 1ns / 1ps
`default_nettype none
module mrp_prep
  import mrp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  output logic up_ready,
  input  sq_t  up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output div_t dn_data
);
  logic [63:0] s2;
  sum_t        sum_next;
  sum_t        sum_q;
  logic        sum_v;
  logic        sum_ready;
  div_t        div_next;

  always_comb begin
    s2 = up_data.sq[0] + up_data.sq[1] + up_data.sq[2];
    sum_next.den = ONE_Q48 + s2;
    if (s2 <= ONE_Q48) begin
      sum_next.num[0] = ONE_Q48 - s2;
      sum_next.neg[0] = up_data.shadow;
    end else begin
      sum_next.num[0] = s2 - ONE_Q48;
      sum_next.neg[0] = !up_data.shadow;
    end
    for (int i = 0; i < 3; i++) begin
      sum_next.num[i+1] = {7'd0, up_data.mag[i], 25'd0};
      sum_next.neg[i+1] = up_data.neg[i] ^ up_data.shadow;
    end
  end

  assign up_ready = !sum_v || sum_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_v <= 1'b0;
    end else if (up_ready) begin
      sum_v <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      sum_q <= sum_next;
    end
  end

  // The integer bit is set only when a numerator equals the denominator.
  always_comb begin
    div_next.den = sum_q.den;
    div_next.neg = sum_q.neg;
    for (int i = 0; i < 4; i++) begin
      if (sum_q.num[i] >= sum_q.den) begin
        div_next.rem[i] = sum_q.num[i] - sum_q.den;
        div_next.quo[i] = 31'd1;
      end else begin
        div_next.rem[i] = sum_q.num[i];
        div_next.quo[i] = 31'd0;
      end
    end
  end

  assign sum_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (sum_ready) begin
      dn_valid <= sum_v;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_ready) begin
      dn_data <= div_next;
    end
  end
endmodule
`default_nettype wire

// ----- sv/mrp_div_stage.sv -----
// One restoring division step for all four lanes.
`timescale 1ns / 1ps
`default_nettype none
module mrp_div_stage
  import mrp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  output logic up_ready,
  input  div_t up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output div_t dn_data
);
  logic [3:0][64:0] shifted;
  div_t             div_next;

  always_comb begin
    div_next.den = up_data.den;
    div_next.neg = up_data.neg;
    for (int i = 0; i < 4; i++) begin
      shifted[i] = {up_data.rem[i], 1'b0};
      if (shifted[i] >= {1'b0, up_data.den}) begin
        div_next.rem[i] = 64'(shifted[i] - {1'b0, up_data.den});
        div_next.quo[i] = {up_data.quo[i][29:0], 1'b1};
      end else begin
        div_next.rem[i] = shifted[i][63:0];
        div_next.quo[i] = {up_data.quo[i][29:0], 1'b0};
      end
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      dn_data <= div_next;
    end
  end
endmodule
`default_nettype wire

// ----- sv/mrp_pack.sv -----
// Last stage: clamp to one, apply the sign and hold the output beat.
`timescale 1ns / 1ps
`default_nettype none
module mrp_pack
  import mrp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  up_valid,
  output logic  up_ready,
  input  div_t  up_data,
  output logic  dn_valid,
  input  logic  dn_ready,
  output quat_t dn_data
);
  logic [3:0][30:0] mag;
  logic [3:0][31:0] word;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i]  = (up_data.quo[i] > ONE_Q30) ? ONE_Q30 : up_data.quo[i];
      word[i] = up_data.neg[i] ? 32'd0 - {1'b0, mag[i]} : {1'b0, mag[i]};
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      dn_data.quat_scalar <= word[0];
      dn_data.quat_x      <= word[1];
      dn_data.quat_y      <= word[2];
      dn_data.quat_z      <= word[3];
    end
  end
endmodule
`default_nettype wire

// ----- sv/mrp_to_quaternion.sv -----
// Top level of the modified Rodrigues parameters to quaternion converter.
//
//   channel   | dir | payload                                   | beat
//   ----------+-----+-------------------------------------------+---------------
//   attitude  | in  | sigma_x/y/z Q7.24, shadow                 | one attitude
//   quat      | out | quat_scalar, quat_x/y/z Q1.30             | one quaternion
//
// An attitude is accepted in every cycle unless a held output beat has backed
// the pipeline up to the input. It passes 34 register stages: one squaring
// stage, one summing stage, one stage for the integer quotient bit, 30
// restoring division stages (one fraction bit each) and the output.
// Throughput is one beat per cycle while no held output beat stalls the input.
// Reset (rst, synchronous) clears only the valid bits of the stages.
// Each stage moves whenever it is empty or its successor moves, so bubbles
// are squeezed out; a held output beat stalls a stage only once every stage
// between it and the output is full.
`timescale 1ns / 1ps
`default_nettype none
module mrp_to_quaternion
  import mrp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  mrp_stream_if.sink   attitude,
  mrp_stream_if.source quat
);
  // Squaring stage output.
  sq_t  sq_data;
  logic sq_valid;
  logic sq_ready;

  // Division chain; entry 0 comes from the prep stages, the last feeds the pack.
  div_t div_data  [0:FRAC_BITS];
  logic div_valid [0:FRAC_BITS];
  logic div_ready [0:FRAC_BITS];

  mrp_square u_square (
    .clk      (clk),
    .rst      (rst),
    .up_valid (attitude.valid),
    .up_ready (attitude.ready),
    .up_data  (attitude.data),
    .dn_valid (sq_valid),
    .dn_ready (sq_ready),
    .dn_data  (sq_data)
  );

  mrp_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .up_valid (sq_valid),
    .up_ready (sq_ready),
    .up_data  (sq_data),
    .dn_valid (div_valid[0]),
    .dn_ready (div_ready[0]),
    .dn_data  (div_data[0])
  );

  // Each stage produces one more fraction bit of all four quotients.
  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
    mrp_div_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (div_valid[k]),
      .up_ready (div_ready[k]),
      .up_data  (div_data[k]),
      .dn_valid (div_valid[k+1]),
      .dn_ready (div_ready[k+1]),
      .dn_data  (div_data[k+1])
    );
  end

  mrp_pack u_pack (
    .clk      (clk),
    .rst      (rst),
    .up_valid (div_valid[FRAC_BITS]),
    .up_ready (div_ready[FRAC_BITS]),
    .up_data  (div_data[FRAC_BITS]),
    .dn_valid (quat.valid),
    .dn_ready (quat.ready),
    .dn_data  (quat.data)
  );
endmodule
`default_nettype wire

// ----- sv/mrp_checker.sv -----
// Port checker for the converter and the bind that attaches it.
`timescale 1ns / 1ps
`default_nettype none
module mrp_checker
  import mrp_pkg::*;
(
  input logic  clk,
  input logic  rst,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input quat_t out_data
);
  localparam logic signed [31:0] QONE = 32'sd1073741824;

  // An empty output register means every stage can move.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("input stalled with empty output");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("output valid right after reset");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.quat_scalar <= QONE && out_data.quat_scalar >= -QONE
      && out_data.quat_x <= QONE && out_data.quat_x >= -QONE
      && out_data.quat_y <= QONE && out_data.quat_y >= -QONE
      && out_data.quat_z <= QONE && out_data.quat_z >= -QONE))
    else $error("quaternion part beyond one");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("output beat dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data)) else $error("stalled beat changed");
endmodule

bind mrp_to_quaternion mrp_checker u_mrp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (attitude.ready),
  .out_valid (quat.valid),
  .out_ready (quat.ready),
  .out_data  (quat.data)
);
`default_nettype wire
